FILE: design/ppt_pkg.sv
// Shared constants, types and helpers for the pointer position tracker.
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

  localparam int CMD_W     = 2;
  localparam int SIZE_W    = 15;
  localparam int POS_W     = 14;
  localparam int VAL_W     = 17;
  localparam int RANGE_W   = 16;
  localparam int BTN_W     = 8;
  localparam int MOVE_W    = 32;
  localparam int CFG_IDX_W = 1;
  localparam int LANES     = 2;

  // serial multiply: one multiplier bit per cycle; serial divide: one quotient bit per cycle
  localparam int PROD_W    = VAL_W + POS_W;
  localparam int REM_W     = RANGE_W + 1;
  localparam int MUL_STEPS = POS_W;
  localparam int DIV_STEPS = PROD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(16384);
  localparam logic [SIZE_W-1:0] SIZE_RESET_W = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] SIZE_RESET_H = SIZE_W'(768);

  localparam logic [CMD_W-1:0] CMD_ABS    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCALED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REL    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SIGN,
    ST_DONE
  } state_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (s > SIZE_MAX) begin
      r = SIZE_MAX;
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/ppt_in_if.sv
// Event channel: valid/ready handshake with one pointer event per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ppt_in_if;
  logic                                 valid;
  logic                                 ready;
  logic        [ppt_pkg::CMD_W-1:0]     cmd;
  logic signed [ppt_pkg::VAL_W-1:0]     x_value;
  logic signed [ppt_pkg::VAL_W-1:0]     y_value;
  logic        [ppt_pkg::RANGE_W-1:0]   x_range;
  logic        [ppt_pkg::RANGE_W-1:0]   y_range;
  logic        [ppt_pkg::BTN_W-1:0]     button_bits;

  modport source (
    output valid, cmd, x_value, y_value, x_range, y_range, button_bits,
    input  ready
  );
  modport sink (
    input  valid, cmd, x_value, y_value, x_range, y_range, button_bits,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ppt_out_if.sv
// Result channel: valid/ready handshake with one pointer status per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ppt_out_if;
  logic                                valid;
  logic                                ready;
  logic        [ppt_pkg::POS_W-1:0]    pos_x;
  logic        [ppt_pkg::POS_W-1:0]    pos_y;
  logic signed [ppt_pkg::MOVE_W-1:0]   move_x;
  logic signed [ppt_pkg::MOVE_W-1:0]   move_y;
  logic        [ppt_pkg::BTN_W-1:0]    buttons_now;
  logic                                absolute_mode;

  modport source (
    output valid, pos_x, pos_y, move_x, move_y, buttons_now, absolute_mode,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, move_x, move_y, buttons_now, absolute_mode,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/ppt_cfg_if.sv
// Register write channel: valid/ready handshake, register index and data per beat.
`timescale 1ns / 1ps
`default_nettype none

interface ppt_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [ppt_pkg::CFG_IDX_W-1:0]       index;
  logic [ppt_pkg::SIZE_W-1:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/pointer_position_tracker.sv
// Pointer position tracker: top level with serial scaling datapath.
//
// Usage:
//   in_bus  takes one pointer event per beat: absolute, scaled absolute or
//           relative (cmd 3 is ignored and just reports the current state).
//   out_bus gives one status beat per event: clamped position, last delta,
//           buttons and absolute flag, taken from the state registers.
//   cfg_bus writes screen_width (index 0) or screen_height (index 1); it is
//           always ready. A write recenters the pointer and clears delta,
//           buttons and flag. Write only while no event is in flight.
// Sequencing:
//   absolute and relative events go from the input beat to ST_DONE and
//   the result register; scaled events first run the serial multiply steps,
//   the restoring divide steps and a sign fixup (ST_MUL, ST_DIV, ST_SIGN),
//   done by the bit-serial shift-add multiplier and divider in each axis lane.
//   One event is worked on at a time; the next beat is taken the cycle
//   after the result is committed, even if that result is not yet taken.
// Reset: synchronous active-low; screen 1024x768, pointer at (512,384),
//   deltas, buttons and flag cleared, no result pending.
// Stall: a finished event waits in ST_DONE until the output register is
//   free; the pending result holds until out_bus.ready.
`timescale 1ns / 1ps
`default_nettype none

module pointer_position_tracker (
  input  wire logic   clk,
  input  wire logic   rst_n,
  ppt_in_if.sink      in_bus,
  ppt_out_if.source   out_bus,
  ppt_cfg_if.sink     cfg_bus
);

  localparam int L = ppt_pkg::LANES;
  localparam int EXT_W = ppt_pkg::MOVE_W - ppt_pkg::POS_W;

  ppt_pkg::state_t state_r, state_nxt;
  logic [ppt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ppt_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic                      out_valid_r, out_valid_nxt;

  logic [ppt_pkg::SIZE_W-1:0] wid_r, wid_nxt, hgt_r, hgt_nxt;
  logic [ppt_pkg::BTN_W-1:0]  btn_r, btn_nxt, btn_in_r, btn_in_nxt;
  logic                       abs_r, abs_nxt;

  // per-axis lane state, lane 0 is x, lane 1 is y
  logic        [ppt_pkg::POS_W-1:0]   cur_r [L];
  logic        [ppt_pkg::POS_W-1:0]   cur_nxt [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  dlt_r [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  dlt_nxt [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  tgt_r [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  tgt_nxt [L];
  logic        [ppt_pkg::PROD_W-1:0]  acc_r [L];
  logic        [ppt_pkg::PROD_W-1:0]  acc_nxt [L];
  logic        [ppt_pkg::REM_W-1:0]   rem_r [L];
  logic        [ppt_pkg::REM_W-1:0]   rem_nxt [L];
  logic        [ppt_pkg::VAL_W-1:0]   mag_r [L];
  logic        [ppt_pkg::VAL_W-1:0]   mag_nxt [L];
  logic        [ppt_pkg::RANGE_W-1:0] dvs_r [L];
  logic        [ppt_pkg::RANGE_W-1:0] dvs_nxt [L];
  logic                               neg_r [L];
  logic                               neg_nxt [L];

  // lane inputs and step results
  logic signed [ppt_pkg::VAL_W-1:0]   val_in [L];
  logic        [ppt_pkg::RANGE_W-1:0] rng_in [L];
  logic        [ppt_pkg::POS_W-1:0]   size_m1 [L];
  logic        [ppt_pkg::VAL_W:0]     mul_sum [L];
  logic        [ppt_pkg::REM_W-1:0]   rem_sh [L];
  logic                               div_ge [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  quo_ext [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  cur_ext [L];
  logic signed [ppt_pkg::MOVE_W-1:0]  val_ext [L];
  logic        [ppt_pkg::POS_W-1:0]   clamped [L];

  logic [ppt_pkg::SIZE_W-1:0] eff_w, eff_h, cfg_w, cfg_h;
  logic                       in_fire, cfg_fire, commit;

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign eff_w = ppt_pkg::eff_size(wid_r);
  assign eff_h = ppt_pkg::eff_size(hgt_r);
  assign cfg_w = ppt_pkg::eff_size((cfg_bus.index == ppt_pkg::REG_WIDTH) ? cfg_bus.data : wid_r);
  assign cfg_h = ppt_pkg::eff_size((cfg_bus.index == ppt_pkg::REG_HEIGHT) ? cfg_bus.data : hgt_r);

  assign val_in[0]  = in_bus.x_value;
  assign val_in[1]  = in_bus.y_value;
  assign rng_in[0]  = in_bus.x_range;
  assign rng_in[1]  = in_bus.y_range;
  assign size_m1[0] = ppt_pkg::POS_W'(eff_w - ppt_pkg::SIZE_W'(1));
  assign size_m1[1] = ppt_pkg::POS_W'(eff_h - ppt_pkg::SIZE_W'(1));

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ppt_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_bus.cmd == ppt_pkg::CMD_SCALED) begin
            state_nxt = ppt_pkg::ST_MUL;
            cnt_nxt   = ppt_pkg::CNT_W'(ppt_pkg::MUL_STEPS - 1);
          end else begin
            state_nxt = ppt_pkg::ST_DONE;
          end
        end
      end
      ppt_pkg::ST_MUL: begin
        if (cnt_r == '0) begin
          state_nxt = ppt_pkg::ST_DIV;
          cnt_nxt   = ppt_pkg::CNT_W'(ppt_pkg::DIV_STEPS - 1);
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ppt_pkg::ST_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = ppt_pkg::ST_SIGN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ppt_pkg::ST_SIGN: state_nxt = ppt_pkg::ST_DONE;
      ppt_pkg::ST_DONE: begin
        if (commit) begin
          state_nxt = ppt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ppt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- outputs ----------------
  always_comb begin
    in_bus.ready  = (state_r == ppt_pkg::ST_IDLE);
    cfg_bus.ready = 1'b1;
    commit        = (state_r == ppt_pkg::ST_DONE) && (!out_valid_r || out_bus.ready);
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.pos_x         = cur_r[0];
  assign out_bus.pos_y         = cur_r[1];
  assign out_bus.move_x        = dlt_r[0];
  assign out_bus.move_y        = dlt_r[1];
  assign out_bus.buttons_now   = btn_r;
  assign out_bus.absolute_mode = abs_r;

  // ---------------- lane step logic ----------------
  always_comb begin
    for (int i = 0; i < L; i++) begin
      mul_sum[i] = {1'b0, acc_r[i][ppt_pkg::PROD_W-1:ppt_pkg::POS_W]} + {1'b0, mag_r[i]};
      rem_sh[i]  = {rem_r[i][ppt_pkg::RANGE_W-1:0], acc_r[i][ppt_pkg::PROD_W-1]};
      div_ge[i]  = rem_sh[i] >= {1'b0, dvs_r[i]};
      quo_ext[i] = $signed({{(ppt_pkg::MOVE_W - ppt_pkg::PROD_W){1'b0}}, acc_r[i]});
      cur_ext[i] = $signed({{EXT_W{1'b0}}, cur_r[i]});
      val_ext[i] = ppt_pkg::MOVE_W'(val_in[i]);
      if (tgt_r[i][ppt_pkg::MOVE_W-1]) begin
        clamped[i] = '0;
      end else if (tgt_r[i] > $signed({{EXT_W{1'b0}}, size_m1[i]})) begin
        clamped[i] = size_m1[i];
      end else begin
        clamped[i] = tgt_r[i][ppt_pkg::POS_W-1:0];
      end
    end
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    wid_nxt       = wid_r;
    hgt_nxt       = hgt_r;
    btn_nxt       = btn_r;
    btn_in_nxt    = btn_in_r;
    abs_nxt       = abs_r;
    for (int i = 0; i < L; i++) begin
      cur_nxt[i] = cur_r[i];
      dlt_nxt[i] = dlt_r[i];
      tgt_nxt[i] = tgt_r[i];
      acc_nxt[i] = acc_r[i];
      rem_nxt[i] = rem_r[i];
      mag_nxt[i] = mag_r[i];
      dvs_nxt[i] = dvs_r[i];
      neg_nxt[i] = neg_r[i];
    end

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_fire) begin
      cmd_nxt    = in_bus.cmd;
      btn_in_nxt = in_bus.button_bits;
      for (int i = 0; i < L; i++) begin
        if (in_bus.cmd == ppt_pkg::CMD_REL) begin
          tgt_nxt[i] = cur_ext[i] + val_ext[i];
        end else begin
          tgt_nxt[i] = val_ext[i];
        end
        // multiplier bits sit in the low end and shift out as the product grows
        acc_nxt[i] = {{ppt_pkg::VAL_W{1'b0}}, size_m1[i]};
        rem_nxt[i] = '0;
        neg_nxt[i] = val_in[i][ppt_pkg::VAL_W-1];
        mag_nxt[i] = val_in[i][ppt_pkg::VAL_W-1] ? (~val_in[i] + 1'b1) : val_in[i];
        dvs_nxt[i] = (rng_in[i] == '0) ? ppt_pkg::RANGE_W'(1) : rng_in[i];
      end
    end

    unique case (state_r)
      ppt_pkg::ST_MUL: begin
        for (int i = 0; i < L; i++) begin
          if (acc_r[i][0]) begin
            acc_nxt[i] = {mul_sum[i], acc_r[i][ppt_pkg::POS_W-1:1]};
          end else begin
            acc_nxt[i] = {1'b0, acc_r[i][ppt_pkg::PROD_W-1:1]};
          end
        end
      end
      ppt_pkg::ST_DIV: begin
        // restoring divide, quotient bits shift in as dividend bits shift out
        for (int i = 0; i < L; i++) begin
          rem_nxt[i] = div_ge[i] ? (rem_sh[i] - {1'b0, dvs_r[i]}) : rem_sh[i];
          acc_nxt[i] = {acc_r[i][ppt_pkg::PROD_W-2:0], div_ge[i]};
        end
      end
      ppt_pkg::ST_SIGN: begin
        for (int i = 0; i < L; i++) begin
          tgt_nxt[i] = neg_r[i] ? (-quo_ext[i]) : quo_ext[i];
        end
      end
      ppt_pkg::ST_DONE: begin
        if (commit) begin
          out_valid_nxt = 1'b1;
          if (cmd_r != ppt_pkg::CMD_NONE) begin
            btn_nxt = btn_in_r;
            abs_nxt = (cmd_r != ppt_pkg::CMD_REL);
            for (int i = 0; i < L; i++) begin
              dlt_nxt[i] = tgt_r[i] - cur_ext[i];
              cur_nxt[i] = clamped[i];
            end
          end
        end
      end
      ppt_pkg::ST_IDLE: ;
      default: ;
    endcase

    // register write recenters with the sizes as written
    if (cfg_fire) begin
      if (cfg_bus.index == ppt_pkg::REG_WIDTH) begin
        wid_nxt = cfg_bus.data;
      end else if (cfg_bus.index == ppt_pkg::REG_HEIGHT) begin
        hgt_nxt = cfg_bus.data;
      end
      cur_nxt[0] = ppt_pkg::POS_W'(cfg_w >> 1);
      cur_nxt[1] = ppt_pkg::POS_W'(cfg_h >> 1);
      dlt_nxt[0] = '0;
      dlt_nxt[1] = '0;
      btn_nxt    = '0;
      abs_nxt    = 1'b0;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ppt_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      wid_r       <= ppt_pkg::SIZE_RESET_W;
      hgt_r       <= ppt_pkg::SIZE_RESET_H;
      cur_r[0]    <= ppt_pkg::POS_W'(ppt_pkg::SIZE_RESET_W >> 1);
      cur_r[1]    <= ppt_pkg::POS_W'(ppt_pkg::SIZE_RESET_H >> 1);
      dlt_r[0]    <= '0;
      dlt_r[1]    <= '0;
      btn_r       <= '0;
      abs_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      wid_r       <= wid_nxt;
      hgt_r       <= hgt_nxt;
      cur_r       <= cur_nxt;
      dlt_r       <= dlt_nxt;
      btn_r       <= btn_nxt;
      abs_r       <= abs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    btn_in_r <= btn_in_nxt;
    tgt_r    <= tgt_nxt;
    acc_r    <= acc_nxt;
    rem_r    <= rem_nxt;
    mag_r    <= mag_nxt;
    dvs_r    <= dvs_nxt;
    neg_r    <= neg_nxt;
  end

  // ---------------- assertions ----------------
  a_pos_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r[0] <= size_m1[0]) && (cur_r[1] <= size_m1[1]))
    else $error("pointer outside the screen");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ppt_pkg::ST_DIV) |-> (rem_r[0] < {1'b0, dvs_r[0]}) &&
                                     (rem_r[1] < {1'b0, dvs_r[1]}))
    else $error("divider remainder not below divisor");

  a_scaled_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_bus.cmd == ppt_pkg::CMD_SCALED)) |=>
      (state_r == ppt_pkg::ST_MUL) && (cnt_r == ppt_pkg::CNT_W'(ppt_pkg::MUL_STEPS - 1)))
    else $error("scaled event did not start the serial multiply");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r && (state_r == ppt_pkg::ST_IDLE))
    else $error("committed event did not raise a result beat");

endmodule

`default_nettype wire

FILE: tb/ppt_checker.sv
// Scoreboard for the pointer position tracker: tracks pointer state and checks status beats.
`timescale 1ns / 1ps

module ppt_checker
  import ppt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  ppt_in_if         in_bus,
  ppt_out_if        out_bus,
  ppt_cfg_if        cfg_bus,
  output int        fail_count,
  output int        pending,
  output int        events_seen,
  output int        writes_seen
);

  typedef struct packed {
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [MOVE_W-1:0] move_x;
    logic [MOVE_W-1:0] move_y;
    logic [BTN_W-1:0]  buttons;
    logic              abs_mode;
  } pointer_status_t;

  // shadow copy of the tracker state
  logic [SIZE_W-1:0] scr_width;
  logic [SIZE_W-1:0] scr_height;
  longint            ptr_x;
  longint            ptr_y;
  longint            move_dx;
  longint            move_dy;
  logic [BTN_W-1:0]  held;
  logic              abs_on;

  pointer_status_t   status_q[$];

  function automatic longint usable_span(logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > SIZE_MAX) return longint'(SIZE_MAX);
    return longint'(s);
  endfunction

  function automatic longint pin_to_screen(longint v, longint span);
    if (v < 0) return 0;
    if (v > span - 1) return span - 1;
    return v;
  endfunction

  function automatic void recenter();
    ptr_x   = usable_span(scr_width) / 2;
    ptr_y   = usable_span(scr_height) / 2;
    move_dx = 0;
    move_dy = 0;
    held    = '0;
    abs_on  = 1'b0;
  endfunction

  function automatic pointer_status_t track_event(
    logic [CMD_W-1:0]          kind,
    logic signed [VAL_W-1:0]   xv,
    logic signed [VAL_W-1:0]   yv,
    logic [RANGE_W-1:0]        xr,
    logic [RANGE_W-1:0]        yr,
    logic [BTN_W-1:0]          btn
  );
    longint          span_x;
    longint          span_y;
    longint          tx;
    longint          ty;
    longint          div_x;
    longint          div_y;
    pointer_status_t s;
    span_x = usable_span(scr_width);
    span_y = usable_span(scr_height);
    case (kind)
      CMD_ABS, CMD_SCALED: begin
        tx = longint'(xv);
        ty = longint'(yv);
        if (kind == CMD_SCALED) begin
          // device range of zero acts as one; division truncates toward zero
          div_x = (xr == '0) ? 1 : longint'(xr);
          div_y = (yr == '0) ? 1 : longint'(yr);
          tx = (tx * (span_x - 1)) / div_x;
          ty = (ty * (span_y - 1)) / div_y;
        end
        move_dx = tx - ptr_x;
        move_dy = ty - ptr_y;
        ptr_x   = pin_to_screen(tx, span_x);
        ptr_y   = pin_to_screen(ty, span_y);
        held    = btn;
        abs_on  = 1'b1;
      end
      CMD_REL: begin
        move_dx = longint'(xv);
        move_dy = longint'(yv);
        ptr_x   = pin_to_screen(ptr_x + longint'(xv), span_x);
        ptr_y   = pin_to_screen(ptr_y + longint'(yv), span_y);
        held    = btn;
        abs_on  = 1'b0;
      end
      default: ;  // unused kind: state untouched, status still reported
    endcase
    s.pos_x    = POS_W'(ptr_x);
    s.pos_y    = POS_W'(ptr_y);
    s.move_x   = MOVE_W'(move_dx);
    s.move_y   = MOVE_W'(move_dy);
    s.buttons  = held;
    s.abs_mode = abs_on;
    return s;
  endfunction

  always @(posedge clk) begin
    pointer_status_t want;
    pointer_status_t got;
    if (!rst_n) begin
      scr_width  = SIZE_RESET_W;
      scr_height = SIZE_RESET_H;
      recenter();
      status_q.delete();
      fail_count  <= 0;
      pending     <= 0;
      events_seen <= 0;
      writes_seen <= 0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        if (cfg_bus.index == REG_WIDTH) begin
          scr_width = cfg_bus.data;
        end else if (cfg_bus.index == REG_HEIGHT) begin
          scr_height = cfg_bus.data;
        end
        recenter();
        writes_seen <= writes_seen + 1;
      end
      if (in_bus.valid && in_bus.ready) begin
        status_q.push_back(track_event(in_bus.cmd, in_bus.x_value, in_bus.y_value,
                                       in_bus.x_range, in_bus.y_range, in_bus.button_bits));
        events_seen <= events_seen + 1;
      end
      if (out_bus.valid && out_bus.ready) begin
        got.pos_x    = out_bus.pos_x;
        got.pos_y    = out_bus.pos_y;
        got.move_x   = out_bus.move_x;
        got.move_y   = out_bus.move_y;
        got.buttons  = out_bus.buttons_now;
        got.abs_mode = out_bus.absolute_mode;
        if (status_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: status beat with no event outstanding", $realtime);
          fail_count <= fail_count + 1;
        end else begin
          want = status_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) begin
              $display("%0t: status mismatch", $realtime);
              $display("  expected pos=(%0d,%0d) move=(%0d,%0d) btn=%h abs=%b",
                       want.pos_x, want.pos_y, $signed(want.move_x), $signed(want.move_y),
                       want.buttons, want.abs_mode);
              $display("  actual   pos=(%0d,%0d) move=(%0d,%0d) btn=%h abs=%b",
                       got.pos_x, got.pos_y, $signed(got.move_x), $signed(got.move_y),
                       got.buttons, got.abs_mode);
            end
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= status_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the pointer position tracker bench: clock, reset, event and register traffic, verdict.
`timescale 1ns / 1ps

module testbench;
  import ppt_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 128;

  logic clk = 1'b0;
  logic rst_n;

  ppt_in_if  ev_bus();
  ppt_out_if st_bus();
  ppt_cfg_if reg_bus();

  int fail_count;
  int pending;
  int events_seen;
  int writes_seen;

  // stimulus-side view of the screen, only used to aim events
  int span_w = 1024;
  int span_h = 768;

  bit tx_gaps   = 1'b1;
  bit rx_steady = 1'b0;
  int hold_asks = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  pointer_position_tracker u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (ev_bus),
    .out_bus(st_bus),
    .cfg_bus(reg_bus)
  );

  ppt_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (ev_bus),
    .out_bus    (st_bus),
    .cfg_bus    (reg_bus),
    .fail_count (fail_count),
    .pending    (pending),
    .events_seen(events_seen),
    .writes_seen(writes_seen)
  );

  // status consumer: random back-pressure, one steady stretch and one long hold-off
  initial begin
    int stall_left;
    stall_left = 0;
    st_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != hold_asks) begin
        holds_done++;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        st_bus.ready <= 1'b0;
      end else if (rx_steady) begin
        st_bus.ready <= 1'b1;
      end else begin
        st_bus.ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (ev_bus.valid && ev_bus.ready) || (st_bus.valid && st_bus.ready) ||
        (reg_bus.valid && reg_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // valid stays high after the beat so back-to-back events need no re-raise
  task automatic send_event(logic [CMD_W-1:0] kind, int x, int y, int xr, int yr, int btn);
    while (tx_gaps && $urandom_range(99) < 37) begin
      ev_bus.valid <= 1'b0;
      @(posedge clk);
    end
    ev_bus.valid       <= 1'b1;
    ev_bus.cmd         <= kind;
    ev_bus.x_value     <= VAL_W'(x);
    ev_bus.y_value     <= VAL_W'(y);
    ev_bus.x_range     <= RANGE_W'(xr);
    ev_bus.y_range     <= RANGE_W'(yr);
    ev_bus.button_bits <= BTN_W'(btn);
    @(posedge clk);
    while (!ev_bus.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    ev_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // both registers in one go, valid held across the two beats
  task automatic write_screen(int w, int h);
    reg_bus.valid <= 1'b1;
    reg_bus.index <= REG_WIDTH;
    reg_bus.data  <= SIZE_W'(w);
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    reg_bus.index <= REG_HEIGHT;
    reg_bus.data  <= SIZE_W'(h);
    @(posedge clk);
    while (!reg_bus.ready) @(posedge clk);
    reg_bus.valid <= 1'b0;
    span_w = (w == 0) ? 1 : ((w > 16384) ? 16384 : w);
    span_h = (h == 0) ? 1 : ((h > 16384) ? 16384 : h);
  endtask

  function automatic int full_value();
    return int'($urandom_range(131071)) - 65536;
  endfunction

  function automatic int edge_value();
    case ($urandom_range(3))
      0: return -65536;
      1: return 65535;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int pick_coord(int span);
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return int'($urandom_range(span - 1));
      5: return span - 1 + int'($urandom_range(3));
      6: return -int'($urandom_range(1, 40));
      7: return edge_value();
      default: return full_value();
    endcase
  endfunction

  function automatic int pick_delta(int span);
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return int'($urandom_range(64)) - 32;
      6: return ($urandom_range(1) == 0) ? span : -span;
      7: return edge_value();
      default: return full_value();
    endcase
  endfunction

  function automatic int pick_range();
    case ($urandom_range(9))
      0: return 0;
      1: return 65535;
      2, 3, 4, 5: return int'($urandom_range(1, 65535));
      default: return int'($urandom_range(1, 1023));
    endcase
  endfunction

  function automatic int pick_device(int r);
    case ($urandom_range(7))
      0, 1, 2, 3, 4: return int'($urandom_range(r));
      5: return r;
      6: return -int'($urandom_range(r));
      default: return full_value();
    endcase
  endfunction

  task automatic random_event();
    int pick;
    int xr;
    int yr;
    pick = $urandom_range(99);
    if (pick < 30) begin
      send_event(CMD_ABS, pick_coord(span_w), pick_coord(span_h),
                 $urandom_range(65535), $urandom_range(65535), $urandom_range(255));
    end else if (pick < 60) begin
      xr = pick_range();
      yr = pick_range();
      send_event(CMD_SCALED, pick_device(xr), pick_device(yr), xr, yr, $urandom_range(255));
    end else if (pick < 95) begin
      send_event(CMD_REL, pick_delta(span_w), pick_delta(span_h),
                 $urandom_range(65535), $urandom_range(65535), $urandom_range(255));
    end else begin
      send_event(CMD_NONE, full_value(), full_value(),
                 $urandom_range(65535), $urandom_range(65535), $urandom_range(255));
    end
  endtask

  initial begin
    int w;
    int h;
    rst_n              <= 1'b0;
    ev_bus.valid       <= 1'b0;
    ev_bus.cmd         <= CMD_ABS;
    ev_bus.x_value     <= '0;
    ev_bus.y_value     <= '0;
    ev_bus.x_range     <= '0;
    ev_bus.y_range     <= '0;
    ev_bus.button_bits <= '0;
    reg_bus.valid      <= 1'b0;
    reg_bus.index      <= REG_WIDTH;
    reg_bus.data       <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed events on the reset screen of 1024x768
    send_event(CMD_ABS, 0, 0, 0, 0, 8'h00);
    send_event(CMD_ABS, 1023, 767, 65535, 65535, 8'hff);
    send_event(CMD_ABS, 65535, 65535, 0, 0, 8'h01);
    send_event(CMD_ABS, -65536, -65536, 0, 0, 8'h80);
    send_event(CMD_ABS, -1, 1024, 0, 0, 8'h55);
    send_event(CMD_REL, 5, -3, 0, 0, 8'haa);
    send_event(CMD_REL, 65535, 65535, 0, 0, 8'h00);
    send_event(CMD_REL, -65536, -65536, 0, 0, 8'hff);
    send_event(CMD_REL, 0, 0, 0, 0, 8'h0f);
    send_event(CMD_NONE, 12345, -777, 65535, 1, 8'hf0);
    send_event(CMD_SCALED, 65535, 65535, 65535, 65535, 8'h02);
    // zero device range acts as one
    send_event(CMD_SCALED, 1, 1, 0, 0, 8'h04);
    send_event(CMD_SCALED, 65535, -65536, 0, 0, 8'h08);
    send_event(CMD_SCALED, -65536, 65535, 1, 1, 8'h10);
    send_event(CMD_SCALED, 32768, 32768, 65535, 65535, 8'h20);
    // negative quotients truncate toward zero
    send_event(CMD_SCALED, -1, -2, 3, 5, 8'h40);
    send_event(CMD_SCALED, 1, 2, 3, 5, 8'h7f);
    send_event(CMD_NONE, -65536, 65535, 0, 0, 8'h00);
    send_event(CMD_ABS, 512, 384, 0, 0, 8'h80);
    send_event(CMD_REL, -1, 1, 0, 0, 8'h01);
    send_event(CMD_NONE, 0, 0, 0, 0, 8'hff);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin w = 1;     h = 1;     end
        1: begin w = 16384; h = 16384; end
        2: begin w = 0;     h = 32767; end
        3: begin w = 16385; h = 0;     end
        4: begin w = 640;   h = 480;   end
        5: begin w = 2;     h = 16384; end
        default: begin
          w = $urandom_range(3, 4000);
          h = $urandom_range(3, 4000);
        end
      endcase
      drain_results();
      write_screen(w, h);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 4) begin
          // steady traffic first, then the consumer stalls while events keep coming
          tx_gaps   = (n >= 80);
          rx_steady = (n < 48);
          if (n == 48) hold_asks++;
        end
        if (ph == 6 && n == PHASE_ITEMS / 2) drain_results();
        random_event();
      end
    end

    drain_results();
    repeat (100) @(posedge clk);
    $display("Covered %0d events of every kind and %0d size writes over %0d screen settings,",
             events_seen, writes_seen, PHASES + 1);
    $display("from 1x1 to 16384 square with zero and over-range sizes, stalls on both sides.");
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
